@@ rtl/mpd_pkg.sv @@
// Package for the minimum partition difference block: sizes, data types,
// controller states and the command and status structs.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package mpd_pkg;

   localparam int MAX_ITEMS   = 16;
   localparam int WEIGHT_BITS = 20;
   localparam int OUT_BITS    = 24;

   localparam int COUNT_BITS = $clog2(MAX_ITEMS + 1);
   localparam int INDEX_BITS = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int SUM_BITS   = WEIGHT_BITS + $clog2(MAX_ITEMS + 1);
   localparam int DIFF_BITS  = SUM_BITS + 1;
   localparam int LIMIT_BITS = MAX_ITEMS + 1;
   localparam int WIDE_BITS  = SUM_BITS + OUT_BITS;

   typedef logic [WEIGHT_BITS-1:0] weight_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [INDEX_BITS-1:0]  index_type;
   typedef logic [MAX_ITEMS-1:0]   mask_type;
   typedef logic [SUM_BITS-1:0]    sum_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;
   typedef logic [OUT_BITS-1:0]    result_type;

   localparam result_type OUT_MAX = '1;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic load;     // a weight word is accepted
      logic start;    // the accepted word closes the set
      logic compare;  // fold |D| into the minimum and step the Gray code
      logic update;   // apply the flipped weight to D
      logic finish;   // capture the result word
   } cmd_type;

   typedef struct packed {
      logic last_mask;  // the split under test is the final one
   } status_type;

   // Index of the lowest set bit; this is the bit that flips between
   // consecutive Gray codes.
   function automatic index_type trailing_zeros(mask_type value);
      index_type pos;
      pos = '0;
      for (int i = MAX_ITEMS - 1; i >= 0; i--) begin
         if (value[i]) begin
            pos = INDEX_BITS'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

@@ rtl/mpd_channels.sv @@
// Channel interfaces of the minimum partition difference block: the weight
// input channel and the result channel, each with valid/ready.
// Depends on mpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mpd_req_if;
   import mpd_pkg::*;

   logic       valid;
   logic       ready;
   weight_type weight;
   logic       is_last;

   modport source (output valid, output weight, output is_last, input ready);
   modport sink (input valid, input weight, input is_last, output ready);
endinterface

interface mpd_rsp_if;
   import mpd_pkg::*;

   logic       valid;
   logic       ready;
   result_type min_difference;

   modport source (output valid, output min_difference, input ready);
   modport sink (input valid, input min_difference, output ready);
endinterface

`default_nettype wire

@@ rtl/mpd_datapath.sv @@
// Datapath of the minimum partition difference block: weight memory, set
// total, running signed difference, Gray-code split counter and minimum.
// Depends on mpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpd_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  mpd_pkg::cmd_type     cmd,
   input  mpd_pkg::weight_type  weight,
   output mpd_pkg::status_type  status,
   output mpd_pkg::result_type  min_difference
);
   import mpd_pkg::*;

   weight_type store_mem [MAX_ITEMS];
   weight_type rd_data_ff;

   count_type  count_ff, count_in;
   sum_type    total_ff, total_in;
   count_type  size_ff, size_in;
   diff_type   diff_ff, diff_in;
   sum_type    best_ff, best_in;
   mask_type   step_ff, step_in;
   mask_type   gray_ff, gray_in;
   logic       add_ff, add_in;
   result_type result_ff, result_in;

   logic                    store_ok;
   sum_type                 total_added;
   mask_type                next_step;
   index_type               rd_index;
   logic [DIFF_BITS-1:0]    diff_mag;
   sum_type                 best_next;
   diff_type                twice_weight;
   logic [LIMIT_BITS-1:0]   step_limit;

   assign store_ok    = count_ff < COUNT_BITS'(MAX_ITEMS);
   assign total_added = store_ok ? total_ff + SUM_BITS'(weight) : total_ff;
   assign next_step   = step_ff + MAX_ITEMS'(1);
   assign rd_index    = trailing_zeros(next_step);

   assign diff_mag  = diff_ff[DIFF_BITS-1] ? DIFF_BITS'(-diff_ff) : DIFF_BITS'(diff_ff);
   assign best_next = (diff_mag[SUM_BITS-1:0] < best_ff) ? diff_mag[SUM_BITS-1:0] : best_ff;

   assign twice_weight = $signed(DIFF_BITS'({rd_data_ff, 1'b0}));

   assign step_limit       = (LIMIT_BITS'(1) << size_ff) - LIMIT_BITS'(1);
   assign status.last_mask = {1'b0, step_ff} == step_limit;

   assign min_difference = result_ff;

   // Weight memory: one write port on load, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.load && store_ok) begin
         store_mem[count_ff[INDEX_BITS-1:0]] <= weight;
      end
      rd_data_ff <= store_mem[rd_index];
   end

   always_comb begin
      count_in  = count_ff;
      total_in  = total_ff;
      size_in   = size_ff;
      diff_in   = diff_ff;
      best_in   = best_ff;
      step_in   = step_ff;
      gray_in   = gray_ff;
      add_in    = add_ff;
      result_in = result_ff;

      if (cmd.load) begin
         count_in = store_ok ? count_ff + COUNT_BITS'(1) : count_ff;
         total_in = total_added;
      end
      if (cmd.start) begin
         // Split zero puts every weight in the second group: D = -total.
         size_in  = store_ok ? count_ff + COUNT_BITS'(1) : count_ff;
         count_in = '0;
         total_in = '0;
         diff_in  = -$signed(DIFF_BITS'(total_added));
         best_in  = '1;
         step_in  = '0;
         gray_in  = '0;
      end
      if (cmd.compare) begin
         best_in = best_next;
         if (!status.last_mask) begin
            step_in           = next_step;
            add_in            = !gray_ff[rd_index];
            gray_in[rd_index] = !gray_ff[rd_index];
         end
      end
      if (cmd.update) begin
         diff_in = add_ff ? diff_ff + twice_weight : diff_ff - twice_weight;
      end
      if (cmd.finish) begin
         result_in = (WIDE_BITS'(best_next) > WIDE_BITS'(OUT_MAX)) ?
                     OUT_MAX : OUT_BITS'(best_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff   <= size_in;
      diff_ff   <= diff_in;
      best_ff   <= best_in;
      step_ff   <= step_in;
      gray_ff   <= gray_in;
      add_ff    <= add_in;
      result_ff <= result_in;
   end

endmodule

`default_nettype wire

@@ rtl/mpd_controller.sv @@
// Controller of the minimum partition difference block: sequences loading
// and the split search, and owns both channel handshakes.
// Depends on mpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpd_controller (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_is_last,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   input  mpd_pkg::status_type  status,
   output mpd_pkg::cmd_type     cmd
);
   import mpd_pkg::*;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      accept;
   logic      out_free;

   assign accept   = req_valid && req_ready;
   assign out_free = !out_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_is_last) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (status.last_mask) begin
               if (out_free) begin
                  state_in = ST_LOAD;
               end
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_COMPARE;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = accept;
            cmd.start = accept && req_is_last;
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            cmd.finish  = status.last_mask && out_free;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/min_partition_difference.sv @@
// Top level of the minimum partition difference block: joins the controller
// and the datapath to the weight and result channels.
// Depends on mpd_pkg, mpd_channels, mpd_controller and mpd_datapath.
//
// Usage: weights arrive on the request channel, one word per accepted
// handshake, and are stored in order, up to MAX_ITEMS of them; further words
// of the same set are dropped. A word with is_last set closes the set and
// starts the search over every split of the stored weights into two groups.
// Splits are visited in Gray-code order, so each step flips one weight from
// one group to the other and adjusts a running signed difference by twice
// that weight. Each split takes a compare step, which folds the difference
// into the minimum and reads the next flipped weight from memory, and an
// update step, which applies that weight to the difference. Loading
// runs at one word per cycle; the request channel is not ready during the
// search. The result sits in an output register, so a new set may load while
// the previous result waits; if the receiver still stalls when the next
// search ends, that search holds until the result word is taken.
// Reset is synchronous and active high: it empties the set, drops any
// pending result and returns to loading. The weight memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module min_partition_difference (
   input wire         clock,
   input wire         reset,
   mpd_req_if.sink    req_chan,
   mpd_rsp_if.source  rsp_chan
);
   import mpd_pkg::*;

   cmd_type    cmd;
   status_type status;
   result_type result;

   mpd_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_is_last (req_chan.is_last),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .status      (status),
      .cmd         (cmd)
   );

   mpd_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .weight         (req_chan.weight),
      .status         (status),
      .min_difference (result)
   );

   // The result word is held in the datapath's output register.
   assign rsp_chan.min_difference = result;

endmodule

`default_nettype wire

@@ tb/tb_min_partition_difference.sv @@
`timescale 1ns / 1ps
// Testbench for min_partition_difference: it sends sets of weight words and predicts each set's
// smallest split difference. It then checks every result word against that prediction.
// Depends on mpd_pkg, mpd_channels and the min_partition_difference RTL.

module tb_min_partition_difference;
   import mpd_pkg::*;

   localparam int RESET_CYCLES   = 11;
   // A full set of sixteen weights searches with no handshake at all. The limit leaves room
   // for several such searches.
   localparam int WATCHDOG_LIMIT = 600000;
   localparam int SETTLE_CYCLES  = 64;
   localparam int LONG_HOLD      = 3000;
   localparam int RANDOM_WORDS   = 1000;
   localparam int STEADY_WORDS   = 240;
   localparam weight_type WEIGHT_MAX = '1;

   logic clock = 1'b0;
   logic reset;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   mpd_req_if req_chan ();
   mpd_rsp_if rsp_chan ();

   min_partition_difference u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // The predictor's own copy of the block's state: the weights of the set being loaded and
   // their count.
   weight_type set_weights [MAX_ITEMS];
   int         set_count = 0;

   // Expected result words, oldest first. One word is pushed when a word carrying is_last is
   // accepted.
   result_type pending_differences [$];
   result_type wanted_difference;

   int error_count  = 0;
   int quiet_cycles = 0;

   // These flags turn random idling on or off on each side. The long hold is a one-shot
   // request to the receiver.
   bit source_idling     = 1'b1;
   bit sink_idling       = 1'b1;
   bit long_hold_request = 1'b0;

   // The predictor tries every split of the stored weights. Bit i of the mask puts weight i
   // in the first group. The smallest absolute difference of the two group sums wins. It
   // saturates at the width of the result word, although the default sizes never get there.
   function automatic result_type best_split_difference(input int count);
      longint unsigned side_a;
      longint unsigned side_b;
      longint unsigned gap;
      longint unsigned best;
      best = '1;
      for (int mask = 0; mask < (1 << count); mask++) begin
         side_a = 0;
         side_b = 0;
         for (int i = 0; i < count; i++) begin
            if (mask[i]) begin
               side_a += set_weights[i];
            end else begin
               side_b += set_weights[i];
            end
         end
         gap = (side_a >= side_b) ? side_a - side_b : side_b - side_a;
         if (gap < best) begin
            best = gap;
         end
      end
      return (best > OUT_MAX) ? OUT_MAX : result_type'(best);
   endfunction

   // This updates the predicted state for one accepted word. A full store drops the word.
   // If that dropped word carries is_last, the search still runs over the stored weights.
   function automatic void predict_word(input weight_type weight, input logic is_last);
      if (set_count < MAX_ITEMS) begin
         set_weights[set_count] = weight;
         set_count++;
      end
      if (is_last) begin
         pending_differences.push_back(best_split_difference(set_count));
         set_count = 0;
      end
   endfunction

   // The weight mix leans on the extremes and on small values, which make ties and zero
   // differences likely. The rest is full-width random, so every weight bit takes both values.
   function automatic weight_type random_weight();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return WEIGHT_MAX;
         2: return weight_type'($urandom_range(0, 15));
         default: return weight_type'($urandom);
      endcase
   endfunction

   // This task offers one word and returns at the edge where it is accepted. An idle burst
   // lowers valid at the edge of the previous acceptance and raises it at a later edge, so valid
   // never gets two assignments in one time step.
   task automatic send_word(input weight_type weight, input logic is_last);
      if (source_idling && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.weight  <= weight;
      req_chan.is_last <= is_last;
      do @(posedge clock); while (!req_chan.ready);
      predict_word(weight, is_last);
   endtask

   task automatic send_set(input int count);
      for (int i = 0; i < count; i++) begin
         send_word(random_weight(), i == count - 1);
      end
   endtask

   // The sender stops offering and waits until every expected result word has come. The
   // first wait always spans one edge, so the next send_word cannot raise valid in the same
   // time step.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_differences.size() != 0);
   endtask

   // A set of one weight, at both extremes of the weight range.
   task automatic test_lone_words();
      send_word('0, 1'b1);
      send_word(WEIGHT_MAX, 1'b1);
   endtask

   // Sets of two weights: one extreme against zero, two equal maxima, and a small odd
   // difference.
   task automatic test_pairs();
      send_word(WEIGHT_MAX, 1'b0);
      send_word('0, 1'b1);
      send_word(WEIGHT_MAX, 1'b0);
      send_word(WEIGHT_MAX, 1'b1);
      send_word(weight_type'(1), 1'b0);
      send_word(weight_type'(2), 1'b1);
   endtask

   // This test fills the store with sixteen words. The seventeenth word is dropped but still
   // closes the set.
   task automatic test_full_store();
      weight_type pattern;
      for (int i = 0; i < MAX_ITEMS; i++) begin
         case (i % 4)
            0: pattern = WEIGHT_MAX;
            1: pattern = weight_type'(20'hAAAAA);
            2: pattern = weight_type'(20'h55555);
            default: pattern = weight_type'(i);
         endcase
         send_word(pattern, 1'b0);
      end
      send_word(WEIGHT_MAX, 1'b1);
      drain_results();
   endtask

   // The receiver holds off for a long stretch while small sets keep coming. The output
   // register fills first. The next search then waits for it to be taken, and the request
   // channel stalls behind that search.
   task automatic test_back_pressure();
      long_hold_request = 1'b1;
      repeat (8) send_set($urandom_range(2, 4));
      drain_results();
   endtask

   // This test sends random sets, mostly small to keep the exhaustive search short. Now and
   // then the sender pauses until every expected result has come.
   task automatic test_random_sets();
      int words_sent;
      int set_index;
      int pick;
      int count;
      words_sent = 0;
      set_index  = 0;
      while (words_sent < RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            count = $urandom_range(1, 6);
         end else if (pick < 95) begin
            count = $urandom_range(7, 10);
         end else begin
            count = $urandom_range(11, 12);
         end
         send_set(count);
         words_sent += count;
         set_index++;
         if (set_index % 25 == 0) begin
            drain_results();
         end
      end
   endtask

   // This is a random set longer than the store can hold. The surplus words are dropped; the
   // last of them carries is_last.
   task automatic test_overfull_set();
      send_set($urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4));
      drain_results();
   endtask

   // The last part runs back to back, with no idling on either side.
   task automatic test_steady_stream();
      int words_sent;
      int count;
      source_idling = 1'b0;
      sink_idling   = 1'b0;
      words_sent    = 0;
      while (words_sent < STEADY_WORDS) begin
         count = $urandom_range(1, 6);
         send_set(count);
         words_sent += count;
      end
   endtask

   // The receiver holds ready low through reset. After reset it alternates random idle bursts
   // with ready stretches, and it serves the long hold when a test asks for one.
   initial begin
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (sink_idling && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // The checker compares each accepted result word with the oldest expectation. The same
   // process counts the cycles in which no handshake completes on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_differences.size() == 0) begin
            $display("%0t: unexpected result word: expected none, actual %0d",
                     $time, rsp_chan.min_difference);
            error_count++;
         end else begin
            wanted_difference = pending_differences.pop_front();
            if (rsp_chan.min_difference !== wanted_difference) begin
               $display("%0t: min_difference mismatch: expected %0d, actual %0d",
                        $time, wanted_difference, rsp_chan.min_difference);
               error_count++;
            end
         end
      end
   end

   // The watchdog ends the run once no handshake has completed for too long.
   initial begin
      do @(posedge clock); while (quiet_cycles < WATCHDOG_LIMIT);
      $display("min_partition_difference verification failed");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.weight  <= '0;
      req_chan.is_last <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_lone_words();
      test_pairs();
      test_full_store();
      test_back_pressure();
      test_random_sets();
      test_overfull_set();
      test_steady_stream();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_differences.size() != 0) begin
         $display("%0t: %0d result words never arrived", $time, pending_differences.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("min_partition_difference verification clean");
      end else begin
         $display("min_partition_difference verification failed");
      end
      $finish;
   end

endmodule
